[hdl/bec_pkg.sv]
// Shared types, constants and a helper function for the button event channel driver.
package bec_pkg;

  // Field widths of the stream items.
  localparam int ENTRY_W   = 6;
  localparam int MODE_W    = 3;
  localparam int CHAN_W    = 7;
  localparam int TIME_W    = 32;
  localparam int VALUE_W   = 16;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VALUE  = 2'd2;

  // Register values after reset.
  localparam logic [15:0]        HOLD_MS_RESET       = 16'd100;
  localparam logic [15:0]        CONTINUOUS_MS_RESET = 16'd50;
  localparam logic signed [15:0] ACTIVE_VALUE_RESET  = 16'sd1000;

  // Behaviour modes.
  localparam logic [MODE_W-1:0] MODE_PRESS         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRESS_RELEASE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CONTINUOUS    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LATCHING      = 3'd4;

  // Depth of the result queue and width of its fill count.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  // State kept for one behaviour entry.
  typedef struct packed {
    logic              pressed;
    logic              released;
    logic              latched;
    logic [TIME_W-1:0] event_time;
  } entry_state_t;

  // One result item.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [CHAN_W-1:0]         channel;
  } result_t;

  // Outcome of servicing one entry.
  typedef struct packed {
    logic                      wr_en;
    logic                      emit;
    logic signed [VALUE_W-1:0] value;
    entry_state_t              state;
  } update_t;

  // A limit has passed when now - (stamp + limit), read as signed, is above zero.
  function automatic logic time_passed(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] stamp,
                                       input logic [15:0]       limit);
    logic [TIME_W-1:0] d;
    d = now - stamp - TIME_W'(limit);
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

[hdl/button_event_channel_driver.sv]
// Top level of the button event channel driver: stream ports, config and pipeline.
//
// Use: each item on s_axis services one behaviour entry (entry, mode, active-low
// button level, channel, millisecond time). The block keeps pressed, released and
// latched flags and an event time per entry in one state memory, and for each item
// emits zero or one result on m_axis: the channel and the value to write (zero or
// active_value).
// An accepted item is registered in the update stage, and its result is then
// written into the result queue, from which it shows on m_axis.
// Throughput: one item per cycle while s_axis_tready is high.
// The state memory is read in the cycle of acceptance and written back in the
// next cycle; a back-to-back item on the same entry takes the written-back
// state from a forwarding register.
// Configuration: cfg_we writes hold_ms, continuous_ms or active_value by cfg_index;
// other indexes are ignored. Write only while the block is idle.
// Reset: rst clears the registers to their defaults, empties the pipeline and the
// result queue, and marks every entry as clear at once; no clearing pass is needed.
// Stall: a four-deep result queue absorbs a stalled receiver; s_axis_tready falls
// only when the queue plus the item in flight would leave no free slot.
module button_event_channel_driver import bec_pkg::*; #(
  parameter int ENTRIES  = 64,
  parameter int CHANNELS = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [5:0] entry, [8:6] mode, [9] button_level, [16:10] channel, [48:17] now_ms
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [6:0] out_channel, [22:7] out_value
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Configuration registers.
  logic [15:0]               hold_ms;
  logic [15:0]               continuous_ms;
  logic signed [VALUE_W-1:0] active_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms       <= HOLD_MS_RESET;
      continuous_ms <= CONTINUOUS_MS_RESET;
      active_value  <= ACTIVE_VALUE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_MS:       hold_ms       <= cfg_data;
        CFG_CONTINUOUS_MS: continuous_ms <= cfg_data;
        CFG_ACTIVE_VALUE:  active_value  <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Input field unpacking.
  logic [ENTRY_W-1:0] in_entry;
  logic [MODE_W-1:0]  in_mode;
  logic               in_level;
  logic [CHAN_W-1:0]  in_channel;
  logic [TIME_W-1:0]  in_now;
  logic [15:0]        in_entry_ext;
  logic [AW-1:0]      in_addr;
  logic               accept;

  assign in_entry     = s_axis_tdata[5:0];
  assign in_mode      = s_axis_tdata[8:6];
  assign in_level     = s_axis_tdata[9];
  assign in_channel   = s_axis_tdata[16:10];
  assign in_now       = s_axis_tdata[48:17];
  assign in_entry_ext = 16'(in_entry);
  assign in_addr      = in_entry_ext[AW-1:0];
  assign accept       = s_axis_tvalid && s_axis_tready;

  // Update stage registers.
  logic               s1_valid;
  logic               s1_in_range;
  logic [AW-1:0]      s1_addr;
  logic [MODE_W-1:0]  s1_mode;
  logic               s1_down;
  logic [CHAN_W-1:0]  s1_channel;
  logic [TIME_W-1:0]  s1_now;
  logic               fwd_hit;
  entry_state_t       fwd_state;

  entry_state_t       mem_rd_data;
  entry_state_t       cur_state;
  update_t            upd;
  logic               s1_wr_en;
  logic               s1_push;
  result_t            s1_result;
  logic [OUTQ_CW-1:0] q_count;
  result_t            q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Payload of the item in the update stage, and forwarding from the write-back.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range <= (in_entry_ext < 16'(ENTRIES));
      s1_addr     <= in_addr;
      s1_mode     <= in_mode;
      s1_down     <= !in_level;
      s1_channel  <= in_channel;
      s1_now      <= in_now;
      fwd_hit     <= s1_wr_en && (s1_addr == in_addr);
      fwd_state   <= upd.state;
    end
  end

  assign cur_state = fwd_hit ? fwd_state : mem_rd_data;

  bec_state_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (mem_rd_data),
    .wr_en   (s1_wr_en),
    .wr_addr (s1_addr),
    .wr_data (upd.state)
  );

  bec_update u_update (
    .mode          (s1_mode),
    .down          (s1_down),
    .now_ms        (s1_now),
    .cur           (cur_state),
    .hold_ms       (hold_ms),
    .continuous_ms (continuous_ms),
    .active_value  (active_value),
    .upd           (upd)
  );

  // Write back and result selection.
  assign s1_wr_en = s1_valid && s1_in_range && upd.wr_en;
  assign s1_push  = s1_wr_en && upd.emit && (16'(s1_channel) < 16'(CHANNELS));
  assign s1_result.channel = s1_channel;
  assign s1_result.value   = upd.value;

  bec_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_push),
    .push_data (s1_result),
    .tvalid    (m_axis_tvalid),
    .tready    (m_axis_tready),
    .tdata_res (q_head),
    .count     (q_count)
  );

  // Accept only while the queue has room for this item and the one in flight.
  assign s_axis_tready = !rst &&
    ((4'(q_count) + 4'(s1_valid) + 4'd1) <= 4'(OUTQ_DEPTH));

  assign m_axis_tdata = {1'b0, q_head.value, q_head.channel};

endmodule

[hdl/bec_state_mem.sv]
// Per-entry state memory with a registered read and per-entry valid bits.
module bec_state_mem import bec_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int AW      = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_state_t rd_data,
  input  logic         wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_state_t wr_data
);

  entry_state_t mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  entry_state_t rd_q;
  logic         rd_written;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits: an entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

[hdl/bec_update.sv]
// Next-state and event logic for one serviced behaviour entry.
module bec_update import bec_pkg::*; (
  input  logic [MODE_W-1:0]         mode,
  input  logic                      down,
  input  logic [TIME_W-1:0]         now_ms,
  input  entry_state_t              cur,
  input  logic [15:0]               hold_ms,
  input  logic [15:0]               continuous_ms,
  input  logic signed [VALUE_W-1:0] active_value,
  output update_t                   upd
);

  logic hold_done;
  logic cont_done;
  logic p, r, l;

  assign hold_done = time_passed(now_ms, cur.event_time, hold_ms);
  assign cont_done = time_passed(now_ms, cur.event_time, continuous_ms);
  assign p = cur.pressed;
  assign r = cur.released;
  assign l = cur.latched;

  // Mode behaviour: every known mode writes its state back.
  always_comb begin
    upd       = '0;
    upd.state = cur;
    upd.wr_en = 1'b1;
    case (mode)
      MODE_PRESS: begin
        if (p) begin
          if (hold_done) begin
            upd.emit = 1'b1;
            if (!down) upd.state.pressed = 1'b0;
          end
        end else if (down) begin
          upd.state.pressed    = 1'b1;
          upd.state.event_time = now_ms;
          upd.emit             = 1'b1;
          upd.value            = active_value;
        end
      end
      MODE_RELEASE: begin
        if (down) begin
          upd.state.pressed = 1'b1;
        end else if (p) begin
          upd.state.pressed    = 1'b0;
          upd.state.released   = 1'b1;
          upd.state.event_time = now_ms;
          upd.emit             = 1'b1;
          upd.value            = active_value;
        end else if (r && hold_done) begin
          upd.state.released = 1'b0;
          upd.emit           = 1'b1;
        end
      end
      MODE_PRESS_RELEASE: begin
        if (down && !p && !r) begin
          upd.state.pressed    = 1'b1;
          upd.state.event_time = now_ms;
          upd.emit             = 1'b1;
          upd.value            = active_value;
        end else if (down && p && !r && hold_done) begin
          upd.emit = 1'b1;
        end else if (!down && p && !r) begin
          upd.state.pressed    = 1'b0;
          upd.state.released   = 1'b1;
          upd.state.event_time = now_ms;
          upd.emit             = 1'b1;
          upd.value            = active_value;
        end else if (!down && !p && r && hold_done) begin
          upd.state.released = 1'b0;
          upd.emit           = 1'b1;
        end
      end
      MODE_CONTINUOUS: begin
        if (p) begin
          if (cont_done) begin
            if (!down) begin
              upd.state.pressed = 1'b0;
              upd.emit          = 1'b1;
            end else begin
              upd.state.event_time = now_ms;
            end
          end
        end else if (down) begin
          upd.state.pressed    = 1'b1;
          upd.state.event_time = now_ms;
          upd.emit             = 1'b1;
          upd.value            = active_value;
        end
      end
      MODE_LATCHING: begin
        if (down && !l && !p && !r) begin
          upd.state.latched = 1'b1;
          upd.state.pressed = 1'b1;
          upd.emit          = 1'b1;
          upd.value         = active_value;
        end else if (!down && l && p && !r) begin
          upd.state.pressed  = 1'b0;
          upd.state.released = 1'b1;
        end else if (down && l && !p && r) begin
          upd.state.released = 1'b0;
          upd.state.latched  = 1'b0;
          upd.state.pressed  = 1'b1;
          upd.emit           = 1'b1;
        end else if (!down && !l && p && !r) begin
          upd.state.pressed = 1'b0;
        end
      end
      default: begin
        upd.wr_en = 1'b0;
      end
    endcase
  end

endmodule

[hdl/bec_outq.sv]
// Small result queue that decouples the update stage from the output stream.
module bec_outq import bec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  output logic                  tvalid,
  input  logic                  tready,
  output result_t               tdata_res,
  output logic [OUTQ_CW-1:0]    count
);

  result_t            slots [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wptr;
  logic [OUTQ_AW-1:0] rptr;
  logic               pop;

  assign tvalid    = (count != '0);
  assign pop       = tvalid && tready;
  assign tdata_res = slots[rptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/bec_checker.sv]
// Port-level checks for the button event channel driver, bound to the top level.
module bec_checker import bec_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // The result queue is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // A stalled result holds its data.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A result appearing on an empty output comes from an item taken through the update stage and the result queue.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching item");

  // With nothing waiting at the output, the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result queue");

endmodule

bind button_event_channel_driver bec_checker u_bec_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/tb.sv]
// Self-checking testbench for the button event channel driver.
module tb;
  import bec_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int ITEM_W        = ENTRY_W + MODE_W + 1 + CHAN_W + TIME_W;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 5;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int DIRECTED_ROWS = 25;

  // Mode code that the block must ignore.
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  // One serviced entry, packed exactly as it travels on s_axis_tdata.
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [CHAN_W-1:0] channel;
    logic              button_level;
    logic [MODE_W-1:0] mode;
    logic [ENTRY_W-1:0] entry;
  } svc_item_t;

  // One channel write expected on m_axis.
  typedef struct packed {
    logic [CHAN_W-1:0]         channel;
    logic signed [VALUE_W-1:0] value;
  } chan_write_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_WRITE
  } check_t;

  typedef struct {
    logic [ENTRY_W-1:0]        entry;
    logic [MODE_W-1:0]         mode;
    logic                      level;
    logic [CHAN_W-1:0]         channel;
    logic [TIME_W-1:0]         now_ms;
    check_t                    chk;
    logic signed [VALUE_W-1:0] value;
  } dir_row_t;

  typedef struct {
    logic [15:0]               hold;
    logic [15:0]               cont;
    logic signed [VALUE_W-1:0] active;
  } setting_t;

  // Receiver stall styles.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } stall_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HOLD_MS;
  logic [15:0]           cfg_data = '0;

  // Predictor copy of the registers and the per-entry state.
  logic [15:0]               hold_reg;
  logic [15:0]               cont_reg;
  logic signed [VALUE_W-1:0] active_reg;
  logic                      is_pressed  [64];
  logic                      is_released [64];
  logic                      is_latched  [64];
  logic [TIME_W-1:0]         stamp_ms    [64];

  chan_write_t pending_writes[$];
  int          mismatches    = 0;
  int          writes_seen   = 0;
  int          directed_sent = 0;
  int          random_sent   = 0;
  int          burst_left    = 0;
  bit          gaps_on       = 1'b1;

  stall_style_t stall_style = RX_OPEN;
  logic [7:0]   stall_tick  = '0;

  // Press, release, press-release, continuous and latching sequences, an unknown mode,
  // and a press that straddles the wrap of the millisecond counter.
  dir_row_t directed [DIRECTED_ROWS] = '{
    '{6'd0,  MODE_PRESS,         1'b0, 7'd0,   32'd0,          CHK_WRITE, 16'sd1000},
    '{6'd0,  MODE_PRESS,         1'b0, 7'd0,   32'd100,        CHK_NONE,  16'sd0},
    '{6'd0,  MODE_PRESS,         1'b0, 7'd0,   32'd101,        CHK_WRITE, 16'sd0},
    '{6'd0,  MODE_PRESS,         1'b0, 7'd0,   32'd150,        CHK_WRITE, 16'sd0},
    '{6'd0,  MODE_PRESS,         1'b1, 7'd0,   32'd160,        CHK_WRITE, 16'sd0},
    '{6'd0,  MODE_PRESS,         1'b1, 7'd0,   32'd170,        CHK_NONE,  16'sd0},
    '{6'd1,  MODE_RELEASE,       1'b0, 7'd127, 32'd1000,       CHK_NONE,  16'sd0},
    '{6'd1,  MODE_RELEASE,       1'b1, 7'd127, 32'd2000,       CHK_WRITE, 16'sd1000},
    '{6'd1,  MODE_RELEASE,       1'b1, 7'd127, 32'd2100,       CHK_NONE,  16'sd0},
    '{6'd1,  MODE_RELEASE,       1'b1, 7'd127, 32'd2101,       CHK_WRITE, 16'sd0},
    '{6'd2,  MODE_PRESS_RELEASE, 1'b0, 7'd85,  32'd10,         CHK_WRITE, 16'sd1000},
    '{6'd2,  MODE_PRESS_RELEASE, 1'b0, 7'd85,  32'd111,        CHK_WRITE, 16'sd0},
    '{6'd2,  MODE_PRESS_RELEASE, 1'b1, 7'd85,  32'd120,        CHK_WRITE, 16'sd1000},
    '{6'd2,  MODE_PRESS_RELEASE, 1'b1, 7'd85,  32'd221,        CHK_WRITE, 16'sd0},
    '{6'd3,  MODE_CONTINUOUS,    1'b0, 7'd42,  32'd500,        CHK_WRITE, 16'sd1000},
    '{6'd3,  MODE_CONTINUOUS,    1'b0, 7'd42,  32'd551,        CHK_MODEL, 16'sd0},
    '{6'd3,  MODE_CONTINUOUS,    1'b1, 7'd42,  32'd601,        CHK_MODEL, 16'sd0},
    '{6'd3,  MODE_CONTINUOUS,    1'b1, 7'd42,  32'd602,        CHK_MODEL, 16'sd0},
    '{6'd4,  MODE_LATCHING,      1'b0, 7'd1,   32'd0,          CHK_WRITE, 16'sd1000},
    '{6'd4,  MODE_LATCHING,      1'b1, 7'd1,   32'd5,          CHK_NONE,  16'sd0},
    '{6'd4,  MODE_LATCHING,      1'b0, 7'd1,   32'd9,          CHK_WRITE, 16'sd0},
    '{6'd4,  MODE_LATCHING,      1'b1, 7'd1,   32'd12,         CHK_NONE,  16'sd0},
    '{6'd5,  MODE_SPARE_HI,      1'b0, 7'd127, 32'hFFFF_FFFF,  CHK_NONE,  16'sd0},
    '{6'd63, MODE_PRESS,         1'b0, 7'd127, 32'hFFFF_FFF0,  CHK_WRITE, 16'sd1000},
    '{6'd63, MODE_PRESS,         1'b0, 7'd127, 32'h0000_0060,  CHK_MODEL, 16'sd0}
  };

  // Register settings per random phase; the fourth one is drawn at random.
  setting_t settings_plan [PHASES] = '{
    '{16'd0,     16'd0,     16'sd32767},
    '{16'd65535, 16'd65535, -16'sd32768},
    '{16'd20,    16'd10,    16'sd0},
    '{16'd100,   16'd50,    16'sd1000},
    '{16'd100,   16'd50,    16'sd1000}
  };

  button_event_channel_driver dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // A limit has passed once now - (stamp + limit), taken as a signed number, is positive.
  function automatic bit limit_elapsed(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] stamp,
                                       input logic [15:0]       limit);
    logic [TIME_W-1:0] diff;
    diff = now - stamp - {16'h0000, limit};
    return $signed(diff) > 0;
  endfunction

  // Services one entry: updates the flags and the event time, and says whether a
  // channel write follows and with which value.
  function automatic void service_entry(input svc_item_t it, output bit emit,
                                        output logic signed [VALUE_W-1:0] val);
    logic              down;
    logic              p;
    logic              r;
    logic              l;
    logic [TIME_W-1:0] t;
    down = !it.button_level;
    p = is_pressed[it.entry];
    r = is_released[it.entry];
    l = is_latched[it.entry];
    t = stamp_ms[it.entry];
    emit = 1'b0;
    val = '0;
    case (it.mode)
      MODE_PRESS: begin
        if (p) begin
          if (limit_elapsed(it.now_ms, t, hold_reg)) begin
            emit = 1'b1;
            if (!down) p = 1'b0;
          end
        end else if (down) begin
          p = 1'b1; t = it.now_ms; emit = 1'b1; val = active_reg;
        end
      end
      MODE_RELEASE: begin
        if (down) begin
          p = 1'b1;
        end else if (p) begin
          p = 1'b0; r = 1'b1; t = it.now_ms; emit = 1'b1; val = active_reg;
        end else if (r && limit_elapsed(it.now_ms, t, hold_reg)) begin
          r = 1'b0; emit = 1'b1;
        end
      end
      MODE_PRESS_RELEASE: begin
        if (down && !p && !r) begin
          p = 1'b1; t = it.now_ms; emit = 1'b1; val = active_reg;
        end else if (down && p && !r && limit_elapsed(it.now_ms, t, hold_reg)) begin
          emit = 1'b1;
        end else if (!down && p && !r) begin
          p = 1'b0; r = 1'b1; t = it.now_ms; emit = 1'b1; val = active_reg;
        end else if (!down && !p && r && limit_elapsed(it.now_ms, t, hold_reg)) begin
          r = 1'b0; emit = 1'b1;
        end
      end
      MODE_CONTINUOUS: begin
        if (p) begin
          if (limit_elapsed(it.now_ms, t, cont_reg)) begin
            if (!down) begin
              p = 1'b0; emit = 1'b1;
            end else begin
              t = it.now_ms;
            end
          end
        end else if (down) begin
          p = 1'b1; t = it.now_ms; emit = 1'b1; val = active_reg;
        end
      end
      MODE_LATCHING: begin
        if (down && !l && !p && !r) begin
          l = 1'b1; p = 1'b1; emit = 1'b1; val = active_reg;
        end else if (!down && l && p && !r) begin
          p = 1'b0; r = 1'b1;
        end else if (down && l && !p && r) begin
          r = 1'b0; l = 1'b0; p = 1'b1; emit = 1'b1;
        end else if (!down && !l && p && !r) begin
          p = 1'b0;
        end
      end
      default: return;
    endcase
    is_pressed[it.entry]  = p;
    is_released[it.entry] = r;
    is_latched[it.entry]  = l;
    stamp_ms[it.entry]    = t;
  endfunction

  // Offers one item, and once it is taken records the channel write it should cause.
  task automatic offer_item(input svc_item_t it, input check_t chk,
                            input logic signed [VALUE_W-1:0] typed_val);
    bit                        emit;
    logic signed [VALUE_W-1:0] val;
    s_axis_tdata  <= {{(IN_DATA_W-ITEM_W){1'b0}}, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    service_entry(it, emit, val);
    if (chk == CHK_NONE) begin
      emit = 1'b0;
    end else if (chk == CHK_WRITE) begin
      emit = 1'b1;
      val  = typed_val;
    end
    if (emit) pending_writes.push_back('{it.channel, val});
    @(negedge clk);
  endtask

  // Items go out in bursts of random length, with random gaps in between unless gaps are off.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Holds the sender back until every expected write has come out and the pipeline
  // has had time to finish items that write nothing.
  task automatic settle_sender();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver stalls, switching style whenever the low six bits of the tick counter are zero.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= (stall_tick[1:0] == 2'd3);
      default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Each result taken is compared with the oldest expected write.
  always @(posedge clk) begin : check_results
    chan_write_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: channel %0d value %0d", $time,
                 m_axis_tdata[6:0], $signed(m_axis_tdata[22:7]));
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        writes_seen++;
        if (m_axis_tdata[6:0] != want.channel) begin
          $display("%0t: out_channel expected %0d actual %0d", $time, want.channel,
                   m_axis_tdata[6:0]);
          mismatches++;
        end
        if ($signed(m_axis_tdata[22:7]) != want.value) begin
          $display("%0t: out_value expected %0d actual %0d", $time, want.value,
                   $signed(m_axis_tdata[22:7]));
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases under several settings.
  initial begin
    svc_item_t  it;
    setting_t   plan;
    int         phase_items;
    int         roll;
    int         span;
    int         e;
    logic [5:0] work_set [8];
    logic [2:0] entry_mode [64];
    logic [6:0] entry_chan [64];
    logic       button_down [64];
    logic [TIME_W-1:0] clock_ms;

    hold_reg   = HOLD_MS_RESET;
    cont_reg   = CONTINUOUS_MS_RESET;
    active_reg = ACTIVE_VALUE_RESET;
    for (int i = 0; i < 64; i++) begin
      is_pressed[i]  = 1'b0;
      is_released[i] = 1'b0;
      is_latched[i]  = 1'b0;
      stamp_ms[i]    = '0;
      button_down[i] = 1'b0;
    end

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table under the reset register values.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      it = '{directed[i].now_ms, directed[i].channel, directed[i].level,
             directed[i].mode, directed[i].entry};
      offer_item(it, directed[i].chk, directed[i].value);
      directed_sent++;
      pace_sender();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      plan = settings_plan[ph];
      // One phase runs with freshly drawn registers.
      if (ph == 3) begin
        plan.hold   = 16'($urandom_range(1, 400));
        plan.cont   = 16'($urandom_range(1, 400));
        plan.active = 16'($urandom());
      end
      settle_sender();
      cfg_we    <= 1'b1;
      cfg_index <= CFG_HOLD_MS;
      cfg_data  <= plan.hold;
      @(negedge clk);
      cfg_index <= CFG_CONTINUOUS_MS;
      cfg_data  <= plan.cont;
      @(negedge clk);
      cfg_index <= CFG_ACTIVE_VALUE;
      cfg_data  <= plan.active;
      @(negedge clk);
      cfg_we <= 1'b0;
      hold_reg   = plan.hold;
      cont_reg   = plan.cont;
      active_reg = plan.active;

      // Fresh working set of entries, each with a fixed mode and channel.
      for (int i = 0; i < 8; i++) work_set[i] = 6'($urandom_range(0, 63));
      for (int i = 0; i < 64; i++) begin
        entry_mode[i] = 3'($urandom_range(0, 4));
        entry_chan[i] = 7'($urandom_range(0, 127));
      end
      clock_ms = $urandom();
      gaps_on  = (ph != 2);
      span = ((hold_reg > cont_reg) ? int'(hold_reg) : int'(cont_reg)) + 2;

      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // Noise: every field drawn at random, unknown modes included.
          it.entry        = 6'($urandom_range(0, 63));
          it.mode         = 3'($urandom_range(0, 7));
          it.button_level = 1'($urandom_range(0, 1));
          it.channel      = 7'($urandom_range(0, 127));
          it.now_ms       = $urandom();
        end else begin
          // Well-formed traffic: time moves forward and the button toggles now and then.
          e = (roll < 20) ? $urandom_range(0, 63) : work_set[$urandom_range(0, 7)];
          if ($urandom_range(0, 9) == 0) clock_ms += $urandom_range(0, 2 * span);
          else clock_ms += $urandom_range(0, span / 3 + 1);
          if ($urandom_range(0, 99) < 35) button_down[e] = !button_down[e];
          it.entry        = 6'(e);
          it.mode         = (roll < 14) ? 3'($urandom_range(0, 4)) : entry_mode[e];
          it.button_level = !button_down[e];
          it.channel      = entry_chan[e];
          it.now_ms       = clock_ms;
        end
        offer_item(it, CHK_MODEL, '0);
        random_sent++;
        if (it.mode <= MODE_LATCHING) phase_items++;
        pace_sender();
        if ($urandom_range(0, 149) == 0) settle_sender();
      end
    end

    settle_sender();
    $display("Sent %0d directed and %0d random items; %0d channel writes checked.",
             directed_sent, random_sent, writes_seen);
    $display("Settings swept zero and full-scale times and both active value extremes.");
    if (mismatches == 0) begin
      $display("button_event_channel_driver: match");
    end else begin
      $display("button_event_channel_driver: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(2 * CLK_HALF * 200000);
    $display("button_event_channel_driver: mismatch");
    $finish;
  end

endmodule
